// ===== hdl/sepf_pkg.sv =====
// Shared types and constants for the sub-pixel edge parabola fit core.
package sepf_pkg;

    // Field widths of the stream items.
    localparam int COORD_BITS  = 12;
    localparam int SLICE_BITS  = 10;
    localparam int SAMPLE_BITS = 16;
    localparam int GRAD_BITS   = 16;
    localparam int FRAC_BITS   = 8;
    localparam int POS_BITS    = 24;
    localparam int PAIR_BITS   = 2 * SAMPLE_BITS;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_RAW_BITS  = 3 * COORD_BITS - COORD_BITS + SLICE_BITS + SAMPLE_BITS
                                  + 2 * GRAD_BITS + 4 * PAIR_BITS;
    localparam int IN_BITS      = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS = 2 * POS_BITS + SLICE_BITS;
    localparam int OUT_BITS     = ((OUT_RAW_BITS + 7) / 8) * 8;
    localparam int USER_BITS    = 3;

    // Fixed-point constants (Q16).
    localparam int MIX_BITS  = 17;
    localparam int MIX_ONE   = 65536;
    localparam int K_SQRT2   = 92681;
    localparam int K_DIST    = 27132;

    // Internal widths of the datapath.
    localparam int SQ_BITS    = 2 * GRAD_BITS;
    localparam int MNUM_BITS  = 32;
    localparam int BPROD_BITS = MIX_BITS + SAMPLE_BITS;
    localparam int V_BITS     = SAMPLE_BITS + 8;
    localparam int DQ_BITS    = 17;
    localparam int DIFF_BITS  = V_BITS + 1;
    localparam int DEN_BITS   = V_BITS + 4;
    localparam int DENM_BITS  = V_BITS + 3;
    localparam int NUMM_BITS  = V_BITS + DQ_BITS;
    localparam int LO_BITS    = 24;
    localparam int HI_BITS    = NUMM_BITS - LO_BITS;
    localparam int UP_BITS    = GRAD_BITS + NUMM_BITS;
    localparam int EXT_BITS   = NUMM_BITS + 2;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_X_LOW  = 2'd0,
        CFG_X_HIGH = 2'd1,
        CFG_Y_LOW  = 2'd2,
        CFG_Y_HIGH = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x_low;
        logic [COORD_BITS-1:0] x_high;
        logic [COORD_BITS-1:0] y_low;
        logic [COORD_BITS-1:0] y_high;
    } cfg_t;

    // Fields the back stages carry along up to stage 6.
    typedef struct packed {
        logic [COORD_BITS-1:0]        px;
        logic [COORD_BITS-1:0]        py;
        logic [SLICE_BITS-1:0]        pz;
        logic                         border;
        logic [SAMPLE_BITS-1:0]       mag;
        logic signed [GRAD_BITS-1:0]  gx;
        logic signed [GRAD_BITS-1:0]  gy;
    } base_t;

    typedef struct packed {
        base_t                  b;
        logic [SAMPLE_BITS-1:0] fa;
        logic [SAMPLE_BITS-1:0] ba;
        logic [SAMPLE_BITS-1:0] fd;
        logic [SAMPLE_BITS-1:0] bd;
        logic                   m_zero;
    } fit_tag_t;

    // Queue entry written by the front part.
    typedef struct packed {
        fit_tag_t             t;
        logic [GRAD_BITS-1:0] ax;
        logic [GRAD_BITS-1:0] ay;
        logic [GRAD_BITS-1:0] m;
    } front_item_t;

    typedef struct packed {
        fit_tag_t             t;
        logic [MNUM_BITS-1:0] mnum;
    } mix_tag_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]       px;
        logic [COORD_BITS-1:0]       py;
        logic [SLICE_BITS-1:0]       pz;
        logic                        border;
        logic                        nofit;
        logic                        neg;
        logic signed [GRAD_BITS-1:0] gx;
        logic signed [GRAD_BITS-1:0] gy;
    } root_tag_t;

endpackage

// ===== hdl/subpixel_edge_parabola_fit_core.sv =====
// Sub-pixel edge localization: streaming top level with configuration registers.
//
// Input stream s_*: one edgel per transfer (position, slice, magnitude,
// gradient and the eight neighbor magnitudes). Output stream m_*: one refined
// position per input, in input order, with border, no-fit and saturation flags
// in m_tuser. Configuration channel cfg_*: writes one 12-bit extent register
// selected by cfg_index; it is always ready and should be written while idle.
//
// Throughput is one edgel per cycle while m_tready does not hold the output.
// From an input transfer to the result being offered, an edgel passes the
// queue, the 32-stage square root, the 17-stage mix divider and the 41-stage
// vertex divider, together with ten arithmetic stages.
//
// A small queue sits between the classifying front part and the arithmetic
// back part. When the receiver holds m_tready low, the back pipeline freezes
// and the queue fills; s_tready falls only once the queue is full.
// Reset clears all valid flags and the queue and restores the extents to
// their full range; data already in flight is dropped.
module subpixel_edge_parabola_fit_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Fields from bit 0 up: pixel_x, pixel_y, slice_z, magnitude, grad_x,
    // grad_y, pair_east_west, pair_north_south, pair_main_diagonal,
    // pair_anti_diagonal, zero padding.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sepf_pkg::IN_BITS-1:0]      s_tdata,
    // Fields from bit 0 up: pos_x, pos_y, pos_z, zero padding.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sepf_pkg::OUT_BITS-1:0]     m_tdata,
    // Fields from bit 0 up: on_border, no_fit, saturated.
    output logic [sepf_pkg::USER_BITS-1:0]    m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sepf_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [sepf_pkg::COORD_BITS-1:0]   cfg_data
);

    sepf_pkg::cfg_t        cfg_reg;
    sepf_pkg::front_item_t q_item;
    logic                  q_valid;
    logic                  pop;

    // Extent registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_low  <= '0;
            cfg_reg.x_high <= '1;
            cfg_reg.y_low  <= '0;
            cfg_reg.y_high <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (sepf_pkg::cfg_idx_t'(cfg_index))
                sepf_pkg::CFG_X_LOW:  cfg_reg.x_low  <= cfg_data;
                sepf_pkg::CFG_X_HIGH: cfg_reg.x_high <= cfg_data;
                sepf_pkg::CFG_Y_LOW:  cfg_reg.y_low  <= cfg_data;
                sepf_pkg::CFG_Y_HIGH: cfg_reg.y_high <= cfg_data;
                default:              cfg_reg        <= cfg_reg;
            endcase
        end
    end

    sepf_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg_reg),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    sepf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== hdl/sepf_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module sepf_isqrt #(
    parameter int IN_W  = 64,
    parameter int TAG_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [IN_W-1:0]      in_rad,
    input  logic [TAG_W-1:0]     in_tag,
    output logic                 out_valid,
    output logic [IN_W/2-1:0]    out_root,
    output logic [TAG_W-1:0]     out_tag
);

    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 2;

    logic [IN_W-1:0]  rad_reg   [OUT_W];
    logic [REM_W-1:0] rem_reg   [OUT_W];
    logic [OUT_W-1:0] root_reg  [OUT_W];
    logic [TAG_W-1:0] tag_reg   [OUT_W];
    logic             valid_reg [OUT_W];

    genvar k;
    for (k = 0; k < OUT_W; k++)
    begin : g_stage
        logic [IN_W-1:0]  rad_prev;
        logic [REM_W-1:0] rem_prev;
        logic [OUT_W-1:0] root_prev;
        logic [TAG_W-1:0] tag_prev;
        logic             valid_prev;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W:0]   trial;
        logic [REM_W-1:0] rem_next;
        logic [OUT_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign rad_prev   = in_rad;
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign tag_prev   = in_tag;
            assign valid_prev = in_valid;
        end
        else
        begin : g_rest
            assign rad_prev   = rad_reg[k-1];
            assign rem_prev   = rem_reg[k-1];
            assign root_prev  = root_reg[k-1];
            assign tag_prev   = tag_reg[k-1];
            assign valid_prev = valid_reg[k-1];
        end

        // Bring down two radicand bits and try the next root bit.
        always_comb
        begin
            rem_sh = {rem_prev[REM_W-3:0], rad_prev[IN_W-1 -: 2]};
            trial  = {1'b0, rem_sh} - {1'b0, root_prev, 2'b01};
            if (!trial[REM_W])
            begin
                rem_next  = trial[REM_W-1:0];
                root_next = {root_prev[OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_prev[OUT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_prev << 2;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                tag_reg[k]  <= tag_prev;
            end
        end
    end

    assign out_valid = valid_reg[OUT_W-1];
    assign out_root  = root_reg[OUT_W-1];
    assign out_tag   = tag_reg[OUT_W-1];

endmodule

// ===== hdl/sepf_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
module sepf_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32,
    parameter int Q_W   = 17,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [Q_W-1:0]   out_quo,
    output logic [TAG_W-1:0] out_tag
);

    // The caller guarantees that the quotient fits in Q_W bits.
    logic [DEN_W-1:0] rem_reg   [Q_W];
    logic [Q_W-1:0]   low_reg   [Q_W];
    logic [Q_W-1:0]   quo_reg   [Q_W];
    logic [DEN_W-1:0] den_reg   [Q_W];
    logic [TAG_W-1:0] tag_reg   [Q_W];
    logic             valid_reg [Q_W];

    genvar k;
    for (k = 0; k < Q_W; k++)
    begin : g_stage
        logic [DEN_W-1:0] rem_prev;
        logic [Q_W-1:0]   low_prev;
        logic [Q_W-1:0]   quo_prev;
        logic [DEN_W-1:0] den_prev;
        logic [TAG_W-1:0] tag_prev;
        logic             valid_prev;
        logic [DEN_W:0]   rem_sh;
        logic [DEN_W:0]   sub;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign rem_prev   = DEN_W'(in_num >> Q_W);
            assign low_prev   = in_num[Q_W-1:0];
            assign quo_prev   = '0;
            assign den_prev   = in_den;
            assign tag_prev   = in_tag;
            assign valid_prev = in_valid;
        end
        else
        begin : g_rest
            assign rem_prev   = rem_reg[k-1];
            assign low_prev   = low_reg[k-1];
            assign quo_prev   = quo_reg[k-1];
            assign den_prev   = den_reg[k-1];
            assign tag_prev   = tag_reg[k-1];
            assign valid_prev = valid_reg[k-1];
        end

        // Shift in the next dividend bit and subtract where it fits.
        always_comb
        begin
            rem_sh   = {rem_prev, low_prev[Q_W-1]};
            sub      = rem_sh - {1'b0, den_prev};
            ge       = rem_sh >= {1'b0, den_prev};
            rem_next = ge ? sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= low_prev << 1;
                quo_reg[k] <= {quo_prev[Q_W-2:0], ge};
                den_reg[k] <= den_prev;
                tag_reg[k] <= tag_prev;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_quo   = quo_reg[Q_W-1];
    assign out_tag   = tag_reg[Q_W-1];

endmodule

// ===== hdl/sepf_front.sv =====
// Front part: accepts edgels, classifies border and sides, and queues them.
module sepf_front #(
    parameter int DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sepf_pkg::IN_BITS-1:0]  s_tdata,
    input  sepf_pkg::cfg_t                cfg,
    input  logic                          pop,
    output logic                          q_valid,
    output sepf_pkg::front_item_t         q_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [sepf_pkg::COORD_BITS-1:0]      px, py;
    logic [sepf_pkg::SLICE_BITS-1:0]      pz;
    logic [sepf_pkg::SAMPLE_BITS-1:0]     mag;
    logic signed [sepf_pkg::GRAD_BITS-1:0] gx, gy;
    logic [sepf_pkg::PAIR_BITS-1:0]       p_ew, p_ns, p_md, p_ad;
    logic [sepf_pkg::SAMPLE_BITS-1:0]     n_e, n_w, n_n, n_s, n_ne, n_sw, n_nw, n_se;
    logic [sepf_pkg::GRAD_BITS-1:0]       ax, ay;
    logic                                 xpos, ypos;
    sepf_pkg::front_item_t                item;

    sepf_pkg::front_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  push, do_pop;

    // Unpack the input transfer, first field in the lowest bits.
    assign px   = s_tdata[11:0];
    assign py   = s_tdata[23:12];
    assign pz   = s_tdata[33:24];
    assign mag  = s_tdata[49:34];
    assign gx   = s_tdata[65:50];
    assign gy   = s_tdata[81:66];
    assign p_ew = s_tdata[113:82];
    assign p_ns = s_tdata[145:114];
    assign p_md = s_tdata[177:146];
    assign p_ad = s_tdata[209:178];

    assign n_e  = p_ew[sepf_pkg::PAIR_BITS-1 -: sepf_pkg::SAMPLE_BITS];
    assign n_w  = p_ew[sepf_pkg::SAMPLE_BITS-1:0];
    assign n_n  = p_ns[sepf_pkg::PAIR_BITS-1 -: sepf_pkg::SAMPLE_BITS];
    assign n_s  = p_ns[sepf_pkg::SAMPLE_BITS-1:0];
    assign n_ne = p_md[sepf_pkg::PAIR_BITS-1 -: sepf_pkg::SAMPLE_BITS];
    assign n_sw = p_md[sepf_pkg::SAMPLE_BITS-1:0];
    assign n_nw = p_ad[sepf_pkg::PAIR_BITS-1 -: sepf_pkg::SAMPLE_BITS];
    assign n_se = p_ad[sepf_pkg::SAMPLE_BITS-1:0];

    // Classify: border test, gradient magnitudes and forward/back neighbors.
    always_comb
    begin
        xpos = !gx[sepf_pkg::GRAD_BITS-1];
        ypos = !gy[sepf_pkg::GRAD_BITS-1];
        ax   = xpos ? gx : (~gx + 1'b1);
        ay   = ypos ? gy : (~gy + 1'b1);

        item.t.b.px     = px;
        item.t.b.py     = py;
        item.t.b.pz     = pz;
        item.t.b.mag    = mag;
        item.t.b.gx     = gx;
        item.t.b.gy     = gy;
        item.t.b.border = (px <= cfg.x_low) || (py <= cfg.y_low) ||
                          (px >= cfg.x_high) || (py >= cfg.y_high);
        item.ax = ax;
        item.ay = ay;
        item.m  = (ax < ay) ? ax : ay;
        item.t.m_zero = (item.m == '0);

        if (ax >= ay)
        begin
            item.t.fa = xpos ? n_e : n_w;
            item.t.ba = xpos ? n_w : n_e;
        end
        else
        begin
            item.t.fa = ypos ? n_n : n_s;
            item.t.ba = ypos ? n_s : n_n;
        end
        item.t.fd = xpos ? (ypos ? n_ne : n_se) : (ypos ? n_nw : n_sw);
        item.t.bd = xpos ? (ypos ? n_sw : n_nw) : (ypos ? n_se : n_ne);
    end

    // Queue between front and back.
    assign s_tready = (count_reg != CNT_W'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign do_pop   = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= item;
    end

endmodule

// ===== hdl/sepf_back.sv =====
// Back part: axis mix, side blending, parabola vertex and position update.
module sepf_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  sepf_pkg::front_item_t          q_item,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sepf_pkg::OUT_BITS-1:0]  m_tdata,
    output logic [sepf_pkg::USER_BITS-1:0] m_tuser
);

    localparam int SQ  = sepf_pkg::SQ_BITS;
    localparam int BP  = sepf_pkg::BPROD_BITS;
    localparam int VB  = sepf_pkg::V_BITS;
    localparam int NM  = sepf_pkg::NUMM_BITS;
    localparam int LB  = sepf_pkg::LO_BITS;
    localparam int HB  = sepf_pkg::HI_BITS;
    localparam int UB  = sepf_pkg::UP_BITS;
    localparam int EB  = sepf_pkg::EXT_BITS;
    localparam int GB  = sepf_pkg::GRAD_BITS;
    localparam int PB  = sepf_pkg::POS_BITS;
    localparam logic signed [EB-1:0] POS_MAX = EB'((1 << (PB - 1)) - 1);
    localparam logic signed [EB-1:0] POS_MIN = -EB'(1 << (PB - 1));

    logic adv;

    // The whole back pipeline moves while the output register can take data.
    assign adv = !m_tvalid || m_tready;
    assign pop = adv;

    // Stage 1: squares of the gradient and the scaled mix numerator.
    logic                            s1_valid_reg;
    sepf_pkg::fit_tag_t              s1_tag_reg;
    logic [SQ-1:0]                   s1_sqx_reg, s1_sqy_reg;
    logic [sepf_pkg::MNUM_BITS-1:0]  s1_mnum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg  <= q_item.t;
            s1_sqx_reg  <= q_item.ax * q_item.ax;
            s1_sqy_reg  <= q_item.ay * q_item.ay;
            s1_mnum_reg <= sepf_pkg::MNUM_BITS'(q_item.m * sepf_pkg::MIX_BITS'(sepf_pkg::K_SQRT2));
        end
    end

    // Stage 2: squared norm.
    logic               s2_valid_reg;
    sepf_pkg::mix_tag_t s2_tag_reg;
    logic [SQ-1:0]      s2_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_tag_reg.t    <= s1_tag_reg;
            s2_tag_reg.mnum <= s1_mnum_reg;
            s2_sum_reg      <= s1_sqx_reg + s1_sqy_reg;
        end
    end

    // Norm in Q16 and the mix quotient.
    logic                          sq_valid;
    logic [SQ-1:0]                 sq_root;
    sepf_pkg::mix_tag_t            sq_tag;
    logic                          d1_valid;
    logic [sepf_pkg::MIX_BITS-1:0] d1_quo;
    sepf_pkg::fit_tag_t            d1_tag;

    sepf_isqrt #(
        .IN_W  (2 * SQ),
        .TAG_W ($bits(sepf_pkg::mix_tag_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s2_valid_reg),
        .in_rad    ({s2_sum_reg, {SQ{1'b0}}}),
        .in_tag    (s2_tag_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    sepf_div #(
        .NUM_W (sepf_pkg::MNUM_BITS + 16),
        .DEN_W (SQ),
        .Q_W   (sepf_pkg::MIX_BITS),
        .TAG_W ($bits(sepf_pkg::fit_tag_t))
    ) u_mix_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sq_valid),
        .in_num    ({sq_tag.mnum, 16'b0}),
        .in_den    (sq_root),
        .in_tag    (sq_tag.t),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_tag   (d1_tag)
    );

    // Stage 3: limit the mix, zero when one gradient component is zero.
    logic                          s3_valid_reg;
    sepf_pkg::fit_tag_t            s3_tag_reg;
    logic [sepf_pkg::MIX_BITS-1:0] s3_mix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= d1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_tag_reg <= d1_tag;
            if (d1_tag.m_zero)
                s3_mix_reg <= '0;
            else if (d1_quo > sepf_pkg::MIX_BITS'(sepf_pkg::MIX_ONE))
                s3_mix_reg <= sepf_pkg::MIX_BITS'(sepf_pkg::MIX_ONE);
            else
                s3_mix_reg <= d1_quo;
        end
    end

    // Stage 4: blend products and distance product.
    logic                          s4_valid_reg;
    sepf_pkg::base_t               s4_base_reg;
    logic [BP-1:0]                 s4_pfa_reg, s4_pfd_reg, s4_pba_reg, s4_pbd_reg;
    logic [sepf_pkg::MNUM_BITS-1:0] s4_dprod_reg;
    logic [sepf_pkg::MIX_BITS-1:0] inv_mix;

    assign inv_mix = sepf_pkg::MIX_BITS'(sepf_pkg::MIX_ONE) - s3_mix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (adv)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_base_reg  <= s3_tag_reg.b;
            s4_pfa_reg   <= inv_mix * s3_tag_reg.fa;
            s4_pba_reg   <= inv_mix * s3_tag_reg.ba;
            s4_pfd_reg   <= s3_mix_reg * s3_tag_reg.fd;
            s4_pbd_reg   <= s3_mix_reg * s3_tag_reg.bd;
            s4_dprod_reg <= sepf_pkg::MNUM_BITS'(s3_mix_reg * 15'(sepf_pkg::K_DIST));
        end
    end

    // Stage 5: side values and fit distance.
    logic                         s5_valid_reg;
    sepf_pkg::base_t              s5_base_reg;
    logic [VB-1:0]                s5_vf_reg, s5_vb_reg;
    logic [sepf_pkg::DQ_BITS-1:0] s5_dq_reg;
    logic [BP:0]                  sum_f, sum_b;

    assign sum_f = s4_pfa_reg + s4_pfd_reg + (BP + 1)'(128);
    assign sum_b = s4_pba_reg + s4_pbd_reg + (BP + 1)'(128);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (adv)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_base_reg <= s4_base_reg;
            s5_vf_reg   <= sum_f[VB+7:8];
            s5_vb_reg   <= sum_b[VB+7:8];
            s5_dq_reg   <= sepf_pkg::DQ_BITS'(sepf_pkg::MIX_ONE) +
                           sepf_pkg::DQ_BITS'(s4_dprod_reg[sepf_pkg::MNUM_BITS-1:16]);
        end
    end

    // Stage 6: slope and curvature terms.
    logic                                s6_valid_reg;
    sepf_pkg::base_t                     s6_base_reg;
    logic signed [sepf_pkg::DIFF_BITS-1:0] s6_diff_reg;
    logic signed [sepf_pkg::DEN_BITS-1:0]  s6_den_reg;
    logic [sepf_pkg::DQ_BITS-1:0]        s6_dq_reg;
    logic [sepf_pkg::DENM_BITS-1:0]      curv;

    assign curv = {2'b00, s5_base_reg.mag, 9'b0} - sepf_pkg::DENM_BITS'(s5_vf_reg)
                  - sepf_pkg::DENM_BITS'(s5_vb_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (adv)
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_base_reg <= s5_base_reg;
            s6_diff_reg <= {1'b0, s5_vf_reg} - {1'b0, s5_vb_reg};
            s6_den_reg  <= {curv, 1'b0};
            s6_dq_reg   <= s5_dq_reg;
        end
    end

    // Stage 7: numerator magnitude, denominator magnitude and quotient sign.
    logic                           s7_valid_reg;
    sepf_pkg::root_tag_t            s7_tag_reg;
    logic [NM-1:0]                  s7_numm_reg;
    logic [sepf_pkg::DENM_BITS-1:0] s7_denm_reg;
    logic [sepf_pkg::DIFF_BITS-1:0] ndiff;
    logic [sepf_pkg::DEN_BITS-1:0]  nden;
    logic [VB-1:0]                  adiff;
    logic [sepf_pkg::DENM_BITS-1:0] aden;

    always_comb
    begin
        ndiff = -s6_diff_reg;
        nden  = -s6_den_reg;
        adiff = s6_diff_reg[sepf_pkg::DIFF_BITS-1] ? ndiff[VB-1:0] : s6_diff_reg[VB-1:0];
        aden  = s6_den_reg[sepf_pkg::DEN_BITS-1] ? nden[sepf_pkg::DENM_BITS-1:0]
                                                 : s6_den_reg[sepf_pkg::DENM_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_valid_reg <= 1'b0;
        else if (adv)
            s7_valid_reg <= s6_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_tag_reg.px     <= s6_base_reg.px;
            s7_tag_reg.py     <= s6_base_reg.py;
            s7_tag_reg.pz     <= s6_base_reg.pz;
            s7_tag_reg.border <= s6_base_reg.border;
            s7_tag_reg.gx     <= s6_base_reg.gx;
            s7_tag_reg.gy     <= s6_base_reg.gy;
            s7_tag_reg.nofit  <= (s6_den_reg == '0);
            s7_tag_reg.neg    <= s6_diff_reg[sepf_pkg::DIFF_BITS-1] ^
                                 s6_den_reg[sepf_pkg::DEN_BITS-1];
            s7_numm_reg       <= adiff * s6_dq_reg;
            s7_denm_reg       <= aden;
        end
    end

    // Vertex offset magnitude in Q16.
    logic                d2_valid;
    logic [NM-1:0]       d2_quo;
    sepf_pkg::root_tag_t d2_tag;

    sepf_div #(
        .NUM_W (NM),
        .DEN_W (sepf_pkg::DENM_BITS),
        .Q_W   (NM),
        .TAG_W ($bits(sepf_pkg::root_tag_t))
    ) u_root_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s7_valid_reg),
        .in_num    (s7_numm_reg),
        .in_den    (s7_denm_reg),
        .in_tag    (s7_tag_reg),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_tag   (d2_tag)
    );

    // Stage 8: partial products of gradient times offset.
    logic                s8_valid_reg;
    sepf_pkg::root_tag_t s8_tag_reg;
    logic                s8_sx_reg, s8_sy_reg;
    logic [GB+LB-1:0]    s8_xlo_reg, s8_ylo_reg;
    logic [GB+HB-1:0]    s8_xhi_reg, s8_yhi_reg;
    logic [GB-1:0]       agx, agy;

    assign agx = d2_tag.gx[GB-1] ? (~d2_tag.gx + 1'b1) : d2_tag.gx;
    assign agy = d2_tag.gy[GB-1] ? (~d2_tag.gy + 1'b1) : d2_tag.gy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_valid_reg <= 1'b0;
        else if (adv)
            s8_valid_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_tag_reg <= d2_tag;
            s8_sx_reg  <= d2_tag.gx[GB-1] ^ d2_tag.neg;
            s8_sy_reg  <= d2_tag.gy[GB-1] ^ d2_tag.neg;
            s8_xlo_reg <= agx * d2_quo[LB-1:0];
            s8_ylo_reg <= agy * d2_quo[LB-1:0];
            s8_xhi_reg <= agx * d2_quo[NM-1:LB];
            s8_yhi_reg <= agy * d2_quo[NM-1:LB];
        end
    end

    // Stage 9: full product and round to nearest, ties away from zero.
    logic                s9_valid_reg;
    sepf_pkg::root_tag_t s9_tag_reg;
    logic                s9_sx_reg, s9_sy_reg;
    logic [NM-1:0]       s9_qx_reg, s9_qy_reg;
    logic [UB:0]         upx, upy;

    assign upx = (UB + 1)'(s8_xlo_reg) + ((UB + 1)'(s8_xhi_reg) << LB) + (UB + 1)'(1 << 15);
    assign upy = (UB + 1)'(s8_ylo_reg) + ((UB + 1)'(s8_yhi_reg) << LB) + (UB + 1)'(1 << 15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s9_valid_reg <= 1'b0;
        else if (adv)
            s9_valid_reg <= s8_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s9_tag_reg <= s8_tag_reg;
            s9_sx_reg  <= s8_sx_reg;
            s9_sy_reg  <= s8_sy_reg;
            s9_qx_reg  <= upx[NM+15:16];
            s9_qy_reg  <= upy[NM+15:16];
        end
    end

    // Output stage: apply the offset and clamp.
    logic                 out_valid_reg;
    logic [PB-1:0]        out_x_reg, out_y_reg;
    logic [sepf_pkg::SLICE_BITS-1:0] out_z_reg;
    logic                 out_border_reg, out_nofit_reg, out_sat_reg;
    logic                 move;
    logic signed [EB-1:0] pos_x, pos_y, off_x, off_y;
    logic                 hi_x, lo_x, hi_y, lo_y;

    always_comb
    begin
        move  = !s9_tag_reg.border && !s9_tag_reg.nofit;
        off_x = s9_sx_reg ? -EB'(s9_qx_reg) : EB'(s9_qx_reg);
        off_y = s9_sy_reg ? -EB'(s9_qy_reg) : EB'(s9_qy_reg);
        pos_x = EB'({s9_tag_reg.px, {sepf_pkg::FRAC_BITS{1'b0}}}) + (move ? off_x : '0);
        pos_y = EB'({s9_tag_reg.py, {sepf_pkg::FRAC_BITS{1'b0}}}) + (move ? off_y : '0);
        hi_x  = pos_x > POS_MAX;
        lo_x  = pos_x < POS_MIN;
        hi_y  = pos_y > POS_MAX;
        lo_y  = pos_y < POS_MIN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s9_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg      <= hi_x ? POS_MAX[PB-1:0] : (lo_x ? POS_MIN[PB-1:0] : pos_x[PB-1:0]);
            out_y_reg      <= hi_y ? POS_MAX[PB-1:0] : (lo_y ? POS_MIN[PB-1:0] : pos_y[PB-1:0]);
            out_z_reg      <= s9_tag_reg.pz;
            out_border_reg <= s9_tag_reg.border;
            out_nofit_reg  <= !s9_tag_reg.border && s9_tag_reg.nofit;
            out_sat_reg    <= hi_x || lo_x || hi_y || lo_y;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sepf_pkg::OUT_BITS'({out_z_reg, out_y_reg, out_x_reg});
    assign m_tuser  = {out_sat_reg, out_nofit_reg, out_border_reg};

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the sub-pixel edge parabola fit core.
module tb;

    // One edgel as it travels on the input stream.
    typedef struct {
        logic [sepf_pkg::COORD_BITS-1:0]       pixel_x;
        logic [sepf_pkg::COORD_BITS-1:0]       pixel_y;
        logic [sepf_pkg::SLICE_BITS-1:0]       slice_z;
        logic [sepf_pkg::SAMPLE_BITS-1:0]      magnitude;
        logic signed [sepf_pkg::GRAD_BITS-1:0] grad_x;
        logic signed [sepf_pkg::GRAD_BITS-1:0] grad_y;
        logic [sepf_pkg::PAIR_BITS-1:0]        pair_ew;
        logic [sepf_pkg::PAIR_BITS-1:0]        pair_ns;
        logic [sepf_pkg::PAIR_BITS-1:0]        pair_md;
        logic [sepf_pkg::PAIR_BITS-1:0]        pair_ad;
    } edgel_t;

    // One refined position as it travels on the output stream.
    typedef struct {
        logic signed [sepf_pkg::POS_BITS-1:0] pos_x;
        logic signed [sepf_pkg::POS_BITS-1:0] pos_y;
        logic [sepf_pkg::SLICE_BITS-1:0]      pos_z;
        logic                                 on_border;
        logic                                 no_fit;
        logic                                 saturated;
    } refined_t;

    // Directed stimulus row; typed rows carry their result, others use the predictor.
    typedef struct {
        edgel_t   item;
        bit       typed;
        refined_t result;
    } directed_row_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [sepf_pkg::IN_BITS-1:0]      s_tdata = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [sepf_pkg::OUT_BITS-1:0]     m_tdata;
    logic [sepf_pkg::USER_BITS-1:0]    m_tuser;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [sepf_pkg::CFG_IDX_BITS-1:0] cfg_index = sepf_pkg::CFG_X_LOW;
    logic [sepf_pkg::COORD_BITS-1:0]   cfg_data = '0;

    // Extents as the block should currently hold them.
    logic [sepf_pkg::COORD_BITS-1:0] ext_x_low = '0, ext_x_high = '1;
    logic [sepf_pkg::COORD_BITS-1:0] ext_y_low = '0, ext_y_high = '1;

    refined_t pending_fits[$];
    int       error_count = 0;
    bit       calm = 1'b0;

    subpixel_edge_parabola_fit_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock: period 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit far above the slowest legal run.
    initial
    begin
        #3000000;
        $display("tb failed");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned blend_side(longint unsigned axis, longint unsigned diag,
                                                   longint unsigned mix);
        return ((65536 - mix) * axis + mix * diag + 128) >> 8;
    endfunction

    // Offset g*root/2^16, rounded to nearest with ties away from zero.
    function automatic longint scaled_offset(longint g, longint root);
        longint p;
        longint unsigned up, q;
        p = g * root;
        up = (p < 0) ? longint'(-p) : p;
        q = (up + 32768) >> 16;
        return (p < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp_coord(longint p, inout logic sat);
        if (p > 8388607)
        begin
            sat = 1'b1;
            return 8388607;
        end
        if (p < -8388608)
        begin
            sat = 1'b1;
            return -8388608;
        end
        return p;
    endfunction

    // Predicts the refined position of one edgel under the current extents.
    function automatic refined_t predict_refined(edgel_t e);
        refined_t res;
        longint unsigned ax, ay, m, mix, r, fa, ba, fd, bd, vf, vb, dq;
        longint unsigned east, west, north, south, ne, sw, nw, se;
        longint gx, gy, diff, den, root, posx, posy;
        logic border, nofit, sat;
        bit xpos, ypos;
        gx = longint'(e.grad_x);
        gy = longint'(e.grad_y);
        east = e.pair_ew[31:16];  west = e.pair_ew[15:0];
        north = e.pair_ns[31:16]; south = e.pair_ns[15:0];
        ne = e.pair_md[31:16];    sw = e.pair_md[15:0];
        nw = e.pair_ad[31:16];    se = e.pair_ad[15:0];
        posx = longint'(e.pixel_x) << sepf_pkg::FRAC_BITS;
        posy = longint'(e.pixel_y) << sepf_pkg::FRAC_BITS;
        border = (e.pixel_x <= ext_x_low) || (e.pixel_y <= ext_y_low) ||
                 (e.pixel_x >= ext_x_high) || (e.pixel_y >= ext_y_high);
        nofit = 1'b0;
        sat = 1'b0;
        if (!border)
        begin
            ax = (gx < 0) ? -gx : gx;
            ay = (gy < 0) ? -gy : gy;
            m = (ax < ay) ? ax : ay;
            mix = 0;
            xpos = gx >= 0;
            ypos = gy >= 0;
            if (m != 0)
            begin
                r = int_sqrt((ax * ax + ay * ay) << 32);
                mix = (r != 0) ? (m * 92681 * 65536) / r : 0;
                if (mix > 65536)
                    mix = 65536;
            end
            // Axis neighbors follow the dominant component, diagonals the quadrant.
            if (ax >= ay)
            begin
                fa = xpos ? east : west;
                ba = xpos ? west : east;
            end
            else
            begin
                fa = ypos ? north : south;
                ba = ypos ? south : north;
            end
            fd = xpos ? (ypos ? ne : se) : (ypos ? nw : sw);
            bd = xpos ? (ypos ? sw : nw) : (ypos ? se : ne);
            vf = blend_side(fa, fd, mix);
            vb = blend_side(ba, bd, mix);
            dq = 65536 + ((27132 * mix) >> 16);
            diff = longint'(vf) - longint'(vb);
            den = 2 * (2 * (longint'(e.magnitude) << 8) - longint'(vf) - longint'(vb));
            if (den == 0)
                nofit = 1'b1;
            else
            begin
                root = (diff * longint'(dq)) / den;
                if (root > (64'sd1 <<< 40))
                    root = 64'sd1 <<< 40;
                if (root < -(64'sd1 <<< 40))
                    root = -(64'sd1 <<< 40);
                posx = posx + scaled_offset(gx, root);
                posy = posy + scaled_offset(gy, root);
            end
        end
        posx = clamp_coord(posx, sat);
        posy = clamp_coord(posy, sat);
        res.pos_x = posx[sepf_pkg::POS_BITS-1:0];
        res.pos_y = posy[sepf_pkg::POS_BITS-1:0];
        res.pos_z = e.slice_z;
        res.on_border = border;
        res.no_fit = nofit;
        res.saturated = sat;
        return res;
    endfunction

    function automatic edgel_t make_edgel(int px, int py, int pz, int mag, int gx, int gy,
                                          logic [31:0] ew, logic [31:0] ns,
                                          logic [31:0] md, logic [31:0] ad);
        edgel_t e;
        e.pixel_x = sepf_pkg::COORD_BITS'(px);
        e.pixel_y = sepf_pkg::COORD_BITS'(py);
        e.slice_z = sepf_pkg::SLICE_BITS'(pz);
        e.magnitude = sepf_pkg::SAMPLE_BITS'(mag);
        e.grad_x = sepf_pkg::GRAD_BITS'(gx);
        e.grad_y = sepf_pkg::GRAD_BITS'(gy);
        e.pair_ew = ew;   e.pair_ns = ns;   e.pair_md = md;   e.pair_ad = ad;
        return e;
    endfunction

    function automatic refined_t make_refined(int x, int y, int z, bit b, bit nf, bit s);
        refined_t r;
        r.pos_x = sepf_pkg::POS_BITS'(x);
        r.pos_y = sepf_pkg::POS_BITS'(y);
        r.pos_z = sepf_pkg::SLICE_BITS'(z);
        r.on_border = b; r.no_fit = nf; r.saturated = s;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
        error_count++;
    endtask

    // Sends one edgel; the expectation is queued on the accepting edge.
    task automatic send_edgel(edgel_t e, bit typed, refined_t typed_result);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = '0;
        s_tdata[209:0] = {e.pair_ad, e.pair_md, e.pair_ns, e.pair_ew, e.grad_y, e.grad_x,
                          e.magnitude, e.slice_z, e.pixel_y, e.pixel_x};
        do
            @(posedge clk);
        while (!s_tready);
        pending_fits.push_back(typed ? typed_result : predict_refined(e));
        @(negedge clk);
    endtask

    task automatic write_extent(sepf_pkg::cfg_idx_t idx,
                                logic [sepf_pkg::COORD_BITS-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            sepf_pkg::CFG_X_LOW:  ext_x_low = value;
            sepf_pkg::CFG_X_HIGH: ext_x_high = value;
            sepf_pkg::CFG_Y_LOW:  ext_y_low = value;
            sepf_pkg::CFG_Y_HIGH: ext_y_high = value;
            default:              ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Lets the block drain completely before the extents change.
    task automatic drain_core();
        s_tvalid = 1'b0;
        while (pending_fits.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    function automatic int coord_in(int lo, int hi);
        if (hi - lo >= 2 && $urandom_range(0, 7) != 0)
            return $urandom_range(lo + 1, hi - 1);
        return $urandom_range(0, 4095);
    endfunction

    function automatic int grad_value(int mode);
        int v;
        case (mode)
            0: v = $urandom_range(0, 65535) - 32768;
            1: v = $urandom_range(0, 1023) - 512;
            default: v = 0;
        endcase
        return v;
    endfunction

    // Random edgel: mostly interior peaks, with noise, flat fits and odd gradients.
    function automatic edgel_t random_edgel();
        edgel_t e;
        int mode, mag, lim, gx, gy;
        logic [31:0] pr[4];
        mode = $urandom_range(0, 15);
        mag = $urandom_range(0, 65535);
        if (mode < 10)
        begin
            mag = $urandom_range(256, 65535);
            lim = mag;
        end
        else
            lim = 65535;
        for (int i = 0; i < 4; i++)
            pr[i] = {16'($urandom_range(0, lim)), 16'($urandom_range(0, lim))};
        if (mode == 14)
        begin
            mag = 0;
            for (int i = 0; i < 4; i++)
                pr[i] = '0;
        end
        gx = grad_value($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
        gy = grad_value($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
        if (mode == 15)
        begin
            gx = 0;
            gy = 0;
        end
        e = make_edgel(coord_in(ext_x_low, ext_x_high), coord_in(ext_y_low, ext_y_high),
                       $urandom_range(0, 1023), mag, gx, gy, pr[0], pr[1], pr[2], pr[3]);
        return e;
    endfunction

    // Output side: random stall per result, compare against the oldest expectation.
    initial
    begin
        int stall;
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        refined_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_fits.size() == 0)
                report_mismatch("unexpected transfer pos_x", $signed(m_tdata[23:0]), 0);
            else
            begin
                want = pending_fits.pop_front();
                if (m_tdata[23:0] !== want.pos_x)
                    report_mismatch("pos_x", $signed(m_tdata[23:0]), want.pos_x);
                if (m_tdata[47:24] !== want.pos_y)
                    report_mismatch("pos_y", $signed(m_tdata[47:24]), want.pos_y);
                if (m_tdata[57:48] !== want.pos_z)
                    report_mismatch("pos_z", m_tdata[57:48], want.pos_z);
                if (m_tuser[0] !== want.on_border)
                    report_mismatch("on_border", m_tuser[0], want.on_border);
                if (m_tuser[1] !== want.no_fit)
                    report_mismatch("no_fit", m_tuser[1], want.no_fit);
                if (m_tuser[2] !== want.saturated)
                    report_mismatch("saturated", m_tuser[2], want.saturated);
            end
        end
    end

    // Main sequence: reset, directed rows, then random phases over several extents.
    initial
    begin
        directed_row_t rows[$];
        directed_row_t row;
        int extents[6][4];
        refined_t none;
        none = make_refined(0, 0, 0, 0, 0, 0);
        extents = '{'{0, 4095, 0, 4095}, '{0, 0, 0, 0}, '{1000, 1200, 2000, 2100},
                    '{4095, 4095, 4095, 4095}, '{0, 0, 0, 0}, '{0, 4095, 0, 4095}};
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Border pixels at every edge of the default extent.
        row.typed = 1;
        row.item = make_edgel(0, 50, 1023, 65535, 32767, -32768, '1, '1, '1, '1);
        row.result = make_refined(0, 12800, 1023, 1, 0, 0);
        rows.push_back(row);
        row.item = make_edgel(4095, 4095, 0, 0, -32768, 32767, 0, 0, 0, 0);
        row.result = make_refined(1048320, 1048320, 0, 1, 0, 0);
        rows.push_back(row);
        row.item = make_edgel(60, 0, 5, 100, 10, 10, 0, 0, 0, 0);
        row.result = make_refined(15360, 0, 5, 1, 0, 0);
        rows.push_back(row);
        row.item = make_edgel(1, 4095, 6, 100, 10, 10, 0, 0, 0, 0);
        row.result = make_refined(256, 1048320, 6, 1, 0, 0);
        rows.push_back(row);
        // Zero curvature: flat neighborhood with zero magnitude.
        row.item = make_edgel(100, 200, 7, 0, 256, 256, 0, 0, 0, 0);
        row.result = make_refined(25600, 51200, 7, 0, 1, 0);
        rows.push_back(row);
        // Predicted rows: quadrants, axis cases, zero gradient, saturation.
        row.typed = 0;
        row.result = none;
        row.item = make_edgel(1, 1, 1, 300, 256, 0, 32'h0100_0080, 32'h0010_0020,
                              32'h0030_0040, 32'h0050_0060);
        rows.push_back(row);
        row.item = make_edgel(2000, 2000, 2, 300, 0, 0, 32'h0100_0080, 32'h0010_0020, 0, 0);
        rows.push_back(row);
        row.item = make_edgel(2000, 2000, 3, 4000, 300, 200, 32'h0200_0100, 32'h0300_0050,
                              32'h0400_0010, 32'h0020_0030);
        rows.push_back(row);
        row.item = make_edgel(2000, 2000, 4, 4000, -300, 200, 32'h0200_0100, 32'h0300_0050,
                              32'h0400_0010, 32'h0020_0030);
        rows.push_back(row);
        row.item = make_edgel(2000, 2000, 5, 4000, -200, -300, 32'h0200_0100, 32'h0300_0050,
                              32'h0400_0010, 32'h0020_0030);
        rows.push_back(row);
        row.item = make_edgel(2000, 2000, 6, 4000, 200, -300, 32'h0200_0100, 32'h0300_0050,
                              32'h0400_0010, 32'h0020_0030);
        rows.push_back(row);
        row.item = make_edgel(3000, 10, 7, 4000, 0, 500, 0, 32'h0300_0050, 0, 0);
        rows.push_back(row);
        row.item = make_edgel(10, 3000, 8, 4000, -777, -777, '1, '1, '1, '1);
        rows.push_back(row);
        row.item = make_edgel(4094, 4094, 9, 32768, 32767, 0, 32'hFFFF_0000, 0, 0, 0);
        rows.push_back(row);
        row.item = make_edgel(1, 1, 10, 32768, -32768, 0, 32'h0000_FFFF, 0, 0, 0);
        rows.push_back(row);
        row.item = make_edgel(2048, 2048, 11, 32768, 32767, 32767, '1, 0, 32'hFFFF_0000, 0);
        rows.push_back(row);
        row.item = make_edgel(2048, 2048, 12, 65535, -32768, -32768, '1, '1, '1, '1);
        rows.push_back(row);
        foreach (rows[i])
            send_edgel(rows[i].item, rows[i].typed, rows[i].result);

        // Random phases, each under its own extents.
        for (int ph = 0; ph < 6; ph++)
        begin
            drain_core();
            if (ph == 1)
                extents[1] = '{$urandom_range(0, 2047), $urandom_range(2048, 4095),
                               $urandom_range(0, 2047), $urandom_range(2048, 4095)};
            if (ph == 4)
                extents[4] = '{$urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(0, 4095), $urandom_range(0, 4095)};
            write_extent(sepf_pkg::CFG_X_LOW, sepf_pkg::COORD_BITS'(extents[ph][0]));
            write_extent(sepf_pkg::CFG_X_HIGH, sepf_pkg::COORD_BITS'(extents[ph][1]));
            write_extent(sepf_pkg::CFG_Y_LOW, sepf_pkg::COORD_BITS'(extents[ph][2]));
            write_extent(sepf_pkg::CFG_Y_HIGH, sepf_pkg::COORD_BITS'(extents[ph][3]));
            calm = (ph == 2);
            for (int n = 0; n < 190; n++)
                send_edgel(random_edgel(), 0, none);
            calm = 1'b0;
        end

        drain_core();
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

// ===== subpixel_edge_parabola_fit_core.f =====
hdl/sepf_pkg.sv
hdl/sepf_isqrt.sv
hdl/sepf_div.sv
hdl/sepf_front.sv
hdl/sepf_back.sv
hdl/subpixel_edge_parabola_fit_core.sv
bench/tb.sv
